/* rtl/core/pidff_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidff_pkg
// Shared widths, types, register indexes and saturation helpers for the
// PID controller with feedforward.
// ----------------------------------------------------------------------------
package pidff_pkg;

	localparam int VAL_W      = 32;              // Q16.16 values
	localparam int GAIN_W     = 16;              // Q4.12 gains
	localparam int ERR_W      = VAL_W + 1;       // exact difference of two values
	localparam int DIFF_W     = ERR_W + 1;       // difference of two errors
	localparam int SUM_W      = 40;              // integral accumulator
	localparam int FRAC_W     = 12;              // gain fraction bits
	localparam int ACC_W      = 58;              // exact sum of four products
	localparam int INC_W      = ACC_W - FRAC_W;  // sum after rounding shift
	localparam int CFG_ADDR_W = 3;

	localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_W - 1);

	typedef enum logic [CFG_ADDR_W-1:0] {
		CFG_GAIN_P  = 3'd0,
		CFG_GAIN_I  = 3'd1,
		CFG_GAIN_D  = 3'd2,
		CFG_GAIN_FF = 3'd3,
		CFG_FF_EN   = 3'd4
	} pidff_cfg_idx_t;

	typedef struct packed {
		logic signed [GAIN_W-1:0] p;
		logic signed [GAIN_W-1:0] i;
		logic signed [GAIN_W-1:0] d;
		logic signed [GAIN_W-1:0] ff;
		logic                     ff_en;
	} pidff_gains_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] target;
		logic signed [VAL_W-1:0] prior;
		logic signed [VAL_W-1:0] position;
		logic signed [ERR_W-1:0] prev_err;
		logic signed [SUM_W-1:0] err_sum;
	} pidff_state_t;

	// clamp a one-bit-grown value to the Q16.16 range
	function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [VAL_W:0] v);
		logic signed [VAL_W-1:0] r;
		if (v[VAL_W] != v[VAL_W-1]) begin
			r = v[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
		end else begin
			r = v[VAL_W-1:0];
		end
		return r;
	endfunction

	function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W:0] v);
		logic signed [SUM_W-1:0] r;
		if (v[SUM_W] != v[SUM_W-1]) begin
			r = v[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		end else begin
			r = v[SUM_W-1:0];
		end
		return r;
	endfunction

	// clamp the rounded increment to the Q16.16 range
	function automatic logic signed [VAL_W-1:0] sat_inc(input logic signed [INC_W-1:0] v);
		logic signed [VAL_W-1:0] r;
		logic                    ovf;
		ovf = (v[INC_W-1:VAL_W-1] != {(INC_W-VAL_W+1){v[INC_W-1]}});
		if (ovf) begin
			r = v[INC_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
		end else begin
			r = v[VAL_W-1:0];
		end
		return r;
	endfunction

endpackage

/* rtl/core/pid_feedforward_controller_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_feedforward_controller_core
// PID position regulator with optional feedforward on target changes.
// ----------------------------------------------------------------------------
// Takes one request word per cycle unless a step word waits on a stalled
// result. A word with tuser 0 loads a new target (the old one is kept for
// the feedforward term) and gives no result; a word with tuser 1 runs one
// control step and gives one result word holding the new position and the
// increment. A result passes through the input register, then the whole step
// (error, saturating integral, four gain products, rounding, saturating
// position update) resolves combinationally into the result register.
// Because the next step needs the position left by this one, that
// combinational datapath is the state feedback loop and sets the clock limit;
// throughput is one request per cycle while results are taken. Values are
// signed Q16.16, gains signed Q4.12; increment and position saturate to 32
// bits, the integral to 40 bits. The user must write gains through the cfg port
// only while the controller is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module pid_feedforward_controller_core import pidff_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write port
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [GAIN_W-1:0]     cfg_wdata,
	// request words
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [VAL_W-1:0]      s_tdata,   // [31:0] target_value
	input  logic                  s_tuser,   // [0] req_type (1 = step)
	// result words
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [2*VAL_W-1:0]    m_tdata    // [31:0] new_position, [63:32] step_increment
);

	// gain registers
	pidff_gains_t gains_q;

	// input register
	logic                    valid_s1;
	logic                    step_s1;
	logic signed [VAL_W-1:0] target_s1;

	// controller state
	pidff_state_t st_q;
	pidff_state_t st_next;

	// result register
	logic                    out_valid_q;
	logic [2*VAL_W-1:0]      out_data_q;

	logic                    fire_s1;
	logic signed [VAL_W-1:0] pos_c;
	logic signed [VAL_W-1:0] inc_c;

	// set-target words never wait on the result side
	assign fire_s1  = valid_s1 & (~step_s1 | ~out_valid_q | m_tready);
	assign s_tready = ~valid_s1 | fire_s1;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// config decode; unused indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q <= '0;
		end else if (cfg_we) begin
			unique case (pidff_cfg_idx_t'(cfg_addr))
				CFG_GAIN_P:  gains_q.p     <= cfg_wdata;
				CFG_GAIN_I:  gains_q.i     <= cfg_wdata;
				CFG_GAIN_D:  gains_q.d     <= cfg_wdata;
				CFG_GAIN_FF: gains_q.ff    <= cfg_wdata;
				CFG_FF_EN:   gains_q.ff_en <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			step_s1   <= s_tuser;
			target_s1 <= s_tdata;
		end
	end

	pidff_step u_step (
		.gains     (gains_q),
		.st        (st_q),
		.is_step   (step_s1),
		.target_in (target_s1),
		.st_next   (st_next),
		.position  (pos_c),
		.increment (inc_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (fire_s1) begin
			st_q <= st_next;
		end
	end

	// result register: refilled in the same cycle it drains
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && step_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && step_s1) begin
			out_data_q <= {inc_c, pos_c};
		end
	end

endmodule

/* rtl/core/pidff_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidff_step
// One control update: next state and result from the current state and
// one request. Pure combinational datapath.
// ----------------------------------------------------------------------------
module pidff_step import pidff_pkg::*; (
	input  pidff_gains_t             gains,
	input  pidff_state_t             st,
	input  logic                     is_step,
	input  logic signed [VAL_W-1:0]  target_in,
	output pidff_state_t             st_next,
	output logic signed [VAL_W-1:0]  position,
	output logic signed [VAL_W-1:0]  increment
);

	logic signed [ERR_W-1:0]            err;
	logic signed [SUM_W:0]              sum_wide;
	logic signed [SUM_W-1:0]            sum_n;
	logic signed [DIFF_W-1:0]           d_err;
	logic signed [ERR_W-1:0]            t_diff;
	logic signed [GAIN_W+ERR_W-1:0]     prod_p;
	logic signed [GAIN_W+SUM_W-1:0]     prod_i;
	logic signed [GAIN_W+DIFF_W-1:0]    prod_d;
	logic signed [GAIN_W+ERR_W-1:0]     prod_ff;
	logic signed [ACC_W-1:0]            acc;
	logic signed [ACC_W-1:0]            acc_rnd;
	logic signed [VAL_W:0]              pos_wide;

	assign err      = ERR_W'(st.target) - ERR_W'(st.position);
	assign sum_wide = (SUM_W+1)'(st.err_sum) + (SUM_W+1)'(err);
	assign sum_n    = sat_sum(sum_wide);
	assign d_err    = DIFF_W'(err) - DIFF_W'(st.prev_err);
	assign t_diff   = ERR_W'(st.target) - ERR_W'(st.prior);

	assign prod_p  = gains.p * err;
	assign prod_i  = gains.i * sum_n;
	assign prod_d  = gains.d * d_err;
	// both arms signed so the product stays a signed multiply
	assign prod_ff = gains.ff_en ? gains.ff * t_diff : (GAIN_W+ERR_W)'(0);

	assign acc = ACC_W'(prod_p) + ACC_W'(prod_i) + ACC_W'(prod_d) + ACC_W'(prod_ff);

	// round half up, then floor shift by the gain fraction
	assign acc_rnd   = acc + ROUND_HALF;
	assign increment = sat_inc(acc_rnd[ACC_W-1:FRAC_W]);

	assign pos_wide = (VAL_W+1)'(st.position) + (VAL_W+1)'(increment);
	assign position = sat_val(pos_wide);

	always_comb begin
		st_next = st;
		if (is_step) begin
			st_next.position = position;
			st_next.prev_err = err;
			st_next.err_sum  = sum_n;
		end else begin
			st_next.prior  = st.target;
			st_next.target = target_in;
		end
	end

endmodule

/* rtl/core/pidff_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidff_checker
// Port-level checks for the PID controller core, bound to the top level.
// ----------------------------------------------------------------------------
module pidff_checker import pidff_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  s_tuser,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [2*VAL_W-1:0]    m_tdata
);

	// position last handed out; reset position is zero
	logic signed [VAL_W-1:0] last_pos_q;
	logic signed [VAL_W-1:0] exp_pos;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_pos_q <= '0;
		end else if (m_tvalid && m_tready) begin
			last_pos_q <= m_tdata[VAL_W-1:0];
		end
	end

	assign exp_pos = sat_val((VAL_W+1)'(last_pos_q) +
		(VAL_W+1)'($signed(m_tdata[2*VAL_W-1:VAL_W])));

	// input side only backs up behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("input stalled without a stalled result");

	// a fresh result needs a step word accepted through the input register
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tuser, 2))
		else $error("result without a step request");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled result changed");

	// each position is the previous one plus this increment, saturated
	a_position_chain: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[VAL_W-1:0]) == exp_pos))
		else $error("position does not follow increment");

endmodule

bind pid_feedforward_controller_core pidff_checker u_pidff_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tvalid  (s_tvalid),
	.s_tready  (s_tready),
	.s_tuser   (s_tuser),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata)
);
